// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every rising clock edge while the reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`endif

// File: hw/rtl/fmam_pkg.sv
package fmam_pkg;

  localparam int unsigned DecimationDefault = 6;
  localparam int unsigned RateFast = 200000;
  localparam int unsigned RateSlow = 48000;
  localparam int unsigned CordicSteps = 16;
  localparam logic signed [63:0] QuarterTurn = 64'sd2097154;

  typedef enum logic {
    MODE_FM = 1'b0,
    MODE_AM = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_PREP,
    BK_CORDIC,
    BK_SQRT,
    BK_OUT
  } bk_state_e;

  typedef struct packed {
    logic signed [14:0] si;
    logic signed [14:0] sq;
    mode_e              mode;
  } dsample_t;

  function automatic logic signed [63:0] step_angle(input logic [3:0] k);
    logic signed [63:0] r;
    begin
      unique case (k)
        4'd0:  r = 64'sd1048577;
        4'd1:  r = 64'sd619011;
        4'd2:  r = 64'sd327068;
        4'd3:  r = 64'sd166025;
        4'd4:  r = 64'sd83335;
        4'd5:  r = 64'sd41708;
        4'd6:  r = 64'sd20859;
        4'd7:  r = 64'sd10430;
        4'd8:  r = 64'sd5215;
        4'd9:  r = 64'sd2608;
        4'd10: r = 64'sd1304;
        4'd11: r = 64'sd652;
        4'd12: r = 64'sd326;
        4'd13: r = 64'sd163;
        4'd14: r = 64'sd81;
        default: r = 64'sd41;
      endcase
      return r;
    end
  endfunction

endpackage

// File: hw/rtl/fmam_front.sv
module fmam_front
  import fmam_pkg::*;
#(
  parameter int unsigned Decimation = DecimationDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] raw_i_i,
  input  logic [7:0] raw_q_i,
  input  mode_e      mode_i,
  output logic       push_o,
  input  logic       full_i,
  output dsample_t   smp_o
);

  localparam int unsigned CntW = $clog2(Decimation + 1);

  logic [1:0]        rot_q;
  logic [CntW-1:0]   cnt_q;
  logic signed [14:0] si_q, sq_q, ri, rq, ni, nq;
  logic              last;

  always_comb begin
    unique case (rot_q)
      2'd0: begin ri = {7'd0, raw_i_i}; rq = {7'd0, raw_q_i}; end
      2'd1: begin ri = 15'sd255 - {7'd0, raw_q_i}; rq = {7'd0, raw_i_i}; end
      2'd2: begin ri = 15'sd255 - {7'd0, raw_i_i}; rq = 15'sd255 - {7'd0, raw_q_i}; end
      default: begin ri = {7'd0, raw_q_i}; rq = 15'sd255 - {7'd0, raw_i_i}; end
    endcase
    ni = si_q + ri - 15'sd127;
    nq = sq_q + rq - 15'sd127;
  end

  assign last    = (cnt_q == CntW'(Decimation - 1));
  assign ready_o = !(last && full_i);
  assign push_o  = valid_i && ready_o && last;
  assign smp_o   = '{si: ni, sq: nq, mode: mode_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= '0;
      cnt_q <= '0;
      si_q  <= '0;
      sq_q  <= '0;
    end else if (valid_i && ready_o) begin
      rot_q <= rot_q + 2'd1;
      if (last) begin
        cnt_q <= '0;
        si_q  <= '0;
        sq_q  <= '0;
      end else begin
        cnt_q <= cnt_q + CntW'(1);
        si_q  <= ni;
        sq_q  <= nq;
      end
    end
  end

endmodule

// File: hw/rtl/fmam_queue.sv
module fmam_queue
  import fmam_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  dsample_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     avail_o,
  output dsample_t data_o
);

  dsample_t  mem_q [2];
  logic      wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign avail_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// File: hw/rtl/fmam_back.sv
module fmam_back
  import fmam_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               avail_i,
  input  dsample_t           smp_i,
  output logic               pop_o,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [15:0] audio_sample_o
);

  bk_state_e state_q, state_d;
  logic signed [14:0] pi_q, pq_q;
  logic signed [29:0] m1_q, m2_q, m3_q, m4_q;
  logic signed [63:0] x_q, y_q, z_q;
  logic [3:0]  k_q;
  logic [31:0] v_q, root_q, bit_q;
  logic signed [17:0] res_val_q;
  logic [17:0] ph_q;
  logic signed [19:0] asum_q;
  logic signed [15:0] out_q;
  logic        ovld_q;

  logic signed [31:0] cr, cj;
  logic signed [63:0] dx, dy;
  logic [31:0] rb;
  logic signed [19:0] nsum, divd;
  logic [17:0] nph;
  logic        emit;

  assign valid_o        = ovld_q;
  assign audio_sample_o = out_q;

  always_comb begin
    cr   = 32'(m1_q) + 32'(m2_q);
    cj   = 32'(m3_q) - 32'(m4_q);
    dx   = x_q >>> k_q;
    dy   = y_q >>> k_q;
    rb   = root_q + bit_q;
    nsum = asum_q + 20'(res_val_q);
    nph  = ph_q + 18'd48000;
    divd = (nsum < 0) ? -((-nsum) >>> 2) : (nsum >>> 2);
  end

  assign emit = (state_q == BK_OUT) && (!ovld_q || ready_i) && (nph >= 18'd200000);

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      BK_IDLE: if (avail_i) begin
        pop_o = 1'b1;
        state_d = (smp_i.mode == MODE_AM) ? BK_SQRT : BK_MUL;
      end
      BK_MUL:    state_d = BK_PREP;
      BK_PREP:   state_d = (cr == 0 && cj == 0) ? BK_OUT : BK_CORDIC;
      BK_CORDIC: if (k_q == 4'd15) state_d = BK_OUT;
      BK_SQRT:   if (bit_q == 32'd0) state_d = BK_OUT;
      BK_OUT:    if (!ovld_q || ready_i) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BK_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pi_q <= '0; pq_q <= '0; ph_q <= '0; asum_q <= '0; out_q <= '0; ovld_q <= 1'b0;
    end else begin
      if (emit) ovld_q <= 1'b1;
      else if (ready_i) ovld_q <= 1'b0;
      if (state_q == BK_IDLE && avail_i && smp_i.mode == MODE_FM) begin
        pi_q <= smp_i.si;
        pq_q <= smp_i.sq;
      end
      if (state_q == BK_OUT && (!ovld_q || ready_i)) begin
        if (nph >= 18'd200000) begin
          ph_q   <= nph - 18'd200000;
          asum_q <= '0;
          out_q  <= divd[15:0];
        end else begin
          ph_q   <= nph;
          asum_q <= nsum;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BK_IDLE: if (avail_i) begin
        m1_q   <= smp_i.si * pi_q;
        m2_q   <= smp_i.sq * pq_q;
        m3_q   <= smp_i.sq * pi_q;
        m4_q   <= smp_i.si * pq_q;
        v_q    <= 32'(30'(smp_i.si) * 30'(smp_i.si)) + 32'(30'(smp_i.sq) * 30'(smp_i.sq));
        root_q <= '0;
        bit_q  <= 32'h4000_0000;
      end
      BK_MUL: begin
        k_q <= '0;
        if (cr < 0) begin
          if (cj >= 0) begin
            x_q <= 64'(cj) <<< 24; y_q <= -(64'(cr) <<< 24); z_q <= QuarterTurn;
          end else begin
            x_q <= -(64'(cj) <<< 24); y_q <= 64'(cr) <<< 24; z_q <= -QuarterTurn;
          end
        end else begin
          x_q <= 64'(cr) <<< 24; y_q <= 64'(cj) <<< 24; z_q <= '0;
        end
      end
      BK_PREP: res_val_q <= '0;
      BK_CORDIC: begin
        k_q <= k_q + 4'd1;
        if (y_q >= 0) begin
          x_q <= x_q + dy; y_q <= y_q - dx; z_q <= z_q + step_angle(k_q);
        end else begin
          x_q <= x_q - dy; y_q <= y_q + dx; z_q <= z_q - step_angle(k_q);
        end
        if (k_q == 4'd15) res_val_q <= (y_q >= 0) ?
            ((z_q + step_angle(k_q) < 0) ? 18'(-((-(z_q + step_angle(k_q))) >>> 8))
                                         : 18'((z_q + step_angle(k_q)) >>> 8)) :
            ((z_q - step_angle(k_q) < 0) ? 18'(-((-(z_q - step_angle(k_q))) >>> 8))
                                         : 18'((z_q - step_angle(k_q)) >>> 8));
      end
      BK_SQRT: begin
        if (bit_q != 32'd0) begin
          if (v_q >= rb) begin
            v_q <= v_q - rb; root_q <= (root_q >> 1) + bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end else begin
          res_val_q <= 18'(root_q);
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/fm_am_iq_demodulator.sv
// Channel   Dir  Handshake          Payload
// in        in   in_valid/in_ready  raw_i_i, raw_q_i
// cfg       in   cfg_valid/ready    demod_mode_i
// out       out  out_valid/ready    audio_sample_o
// One raw pair per cycle is taken while the front accumulates; every Decimation pairs
// a sample enters a two-entry queue. The back end runs 16 CORDIC steps per FM sample
// (skipped for a zero product) and a square root per AM sample, one root bit a step.
// Reset is asynchronous, active low; the mode register resets to FM.
// A full queue stalls the front on the last pair of a group only.
module fm_am_iq_demodulator
  import fmam_pkg::*;
#(
  parameter int unsigned Decimation = DecimationDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         raw_i_i,
  input  logic [7:0]         raw_q_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               demod_mode_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] audio_sample_o
);

  mode_e    mode_q;
  logic     push, full, pop, avail;
  dsample_t fs, qs;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= MODE_FM;
    else if (cfg_valid_i) mode_q <= mode_e'(demod_mode_i);
  end

  fmam_front #(.Decimation(Decimation)) u_front (
    .clk_i, .rst_ni, .valid_i(in_valid_i), .ready_o(in_ready_o),
    .raw_i_i, .raw_q_i, .mode_i(mode_q), .push_o(push), .full_i(full), .smp_o(fs)
  );

  fmam_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(fs), .full_o(full),
    .pop_i(pop), .avail_o(avail), .data_o(qs)
  );

  fmam_back u_back (
    .clk_i, .rst_ni, .avail_i(avail), .smp_i(qs), .pop_o(pop),
    .valid_o(out_valid_o), .ready_i(out_ready_i), .audio_sample_o
  );

endmodule

// File: hw/rtl/fmam_checker.sv
`include "assert_macros.svh"
module fmam_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] audio_sample_o,
  input logic               cfg_ready_o
);
  `ASSERT_CLK(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(audio_sample_o))
  `ASSERT_CLK(a_range, clk_i, rst_ni, out_valid_o |-> audio_sample_o <= 16'sd20480 && audio_sample_o >= -16'sd20480)
  `ASSERT_CLK(a_cfg, clk_i, rst_ni, cfg_ready_o)
endmodule

bind fm_am_iq_demodulator fmam_checker u_chk (.*);

// File: test/testbench.sv
module testbench;
  import fmam_pkg::*;

  localparam int unsigned HoldLimit = 20000;
  localparam int unsigned RandomItems = 750;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] raw_i_i = '0;
  logic [7:0] raw_q_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic demod_mode_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] audio_sample_o;

  always #4 clk_i = ~clk_i;

  fm_am_iq_demodulator dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .raw_i_i(raw_i_i),
    .raw_q_i(raw_q_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .demod_mode_i(demod_mode_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .audio_sample_o(audio_sample_o)
  );

  mode_e mode_q;
  logic [1:0] rot_q;
  int unsigned grp_cnt;
  longint acc_i, acc_q, last_i, last_q, rs_phase, audio_acc;
  logic signed [15:0] audio_q[$];
  int errors = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  bit hold_off = 1'b0;
  int unsigned quiet = 0;

  function automatic longint fshr(longint v, int unsigned k);
    return v >>> k;
  endfunction

  function automatic longint cordic_angle(longint re, longint im);
    longint x, y, z, t, dx, dy;
    longint steps[16] = '{1048577, 619011, 327068, 166025, 83335, 41708, 20859,
                          10430, 5215, 2608, 1304, 652, 326, 163, 81, 41};
    z = 0;
    if (re == 0 && im == 0) return 0;
    x = re * 64'sd16777216;
    y = im * 64'sd16777216;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = QuarterTurn;
      end else begin
        t = x; x = -y; y = t; z = -QuarterTurn;
      end
    end
    for (int k = 0; k < 16; k++) begin
      dx = fshr(x, k);
      dy = fshr(y, k);
      if (y >= 0) begin
        x += dy; y -= dx; z += steps[k];
      end else begin
        x -= dy; y += dx; z -= steps[k];
      end
    end
    return (z < 0) ? -((-z) >>> 8) : (z >>> 8);
  endfunction

  function automatic longint isqrt(longint v);
    longint r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic bit demod_pair(input logic [7:0] bi, input logic [7:0] bq,
                                    output logic signed [15:0] smp);
    longint ri, rq, v;
    smp = '0;
    case (rot_q)
      2'd0: begin ri = bi; rq = bq; end
      2'd1: begin ri = 255 - bq; rq = bi; end
      2'd2: begin ri = 255 - bi; rq = 255 - bq; end
      default: begin ri = bq; rq = 255 - bi; end
    endcase
    rot_q++;
    acc_i += ri - 127;
    acc_q += rq - 127;
    grp_cnt++;
    if (grp_cnt < 6) return 1'b0;
    if (mode_q == MODE_FM) begin
      v = cordic_angle(acc_i * last_i + acc_q * last_q, acc_q * last_i - acc_i * last_q);
      last_i = acc_i;
      last_q = acc_q;
    end else begin
      v = isqrt(acc_i * acc_i + acc_q * acc_q);
    end
    grp_cnt = 0;
    acc_i = 0;
    acc_q = 0;
    audio_acc += v;
    rs_phase += RateSlow;
    if (rs_phase < RateFast) return 1'b0;
    smp = 16'(audio_acc / 4);
    rs_phase -= RateFast;
    audio_acc = 0;
    return 1'b1;
  endfunction

  task automatic send_pair(input logic [7:0] bi, input logic [7:0] bq,
                           input bit known, input logic signed [15:0] want);
    logic signed [15:0] smp;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_i_i <= bi;
    raw_q_i <= bq;
    do @(posedge clk_i); while (!in_ready_o);
    if (demod_pair(bi, bq, smp)) begin
      if (known && smp != want) begin
        $error("table row: audio_sample expected %0d, predictor %0d", want, smp);
        errors++;
      end
      audio_q.push_back(smp);
    end
  endtask

  task automatic set_mode(input mode_e m);
    in_valid_i <= 1'b0;
    while (audio_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    demod_mode_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mode_q = m;
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (audio_q.size() == 0) begin
        $error("audio_sample: no transfer expected, got %0d", audio_sample_o);
        errors++;
      end else begin
        if (audio_sample_o !== audio_q[0]) begin
          $error("audio_sample expected %0d actual %0d", audio_q[0], audio_sample_o);
          errors++;
        end
        void'(audio_q.pop_front());
      end
    end
    out_ready_i <= !hold_off && ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > HoldLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  typedef struct {
    logic [7:0] bi;
    logic [7:0] bq;
  } pair_t;

  initial begin
    pair_t rows[24];
    int unsigned phase_sel;
    mode_e m;
    mode_q = MODE_FM;
    rot_q = '0;
    grp_cnt = 0;
    acc_i = 0; acc_q = 0; last_i = 0; last_q = 0; rs_phase = 0; audio_acc = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // all-midscale first group: zero product gives zero
    for (int r = 0; r < 24; r++) begin
      case (r / 6)
        0: rows[r] = '{8'd127, 8'd127};
        1: rows[r] = '{8'd255, 8'd0};
        2: rows[r] = '{8'd0, 8'd255};
        default: rows[r] = '{8'(r * 37), 8'(r * 91)};
      endcase
    end
    for (int r = 0; r < 24; r++) send_pair(rows[r].bi, rows[r].bq, r < 6, 16'sd0);
    set_mode(MODE_AM);
    for (int r = 0; r < 24; r++) send_pair(rows[r].bi, rows[r].bq, 1'b0, 16'sd0);
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 150 == 0) begin
        phase_sel = n / 150;
        m = mode_e'($urandom_range(1));
        if (phase_sel == 2) m = MODE_FM;
        if (phase_sel == 3) m = MODE_AM;
        set_mode(m);
        case (phase_sel)
          0: begin in_idle_pct = 0; out_stall_pct = 0; end
          1: begin in_idle_pct = 70; out_stall_pct = 0; end
          2: begin in_idle_pct = 0; out_stall_pct = 70; end
          3: begin in_idle_pct = 13; out_stall_pct = 13; end
          default: begin in_idle_pct = 0; out_stall_pct = 0; end
        endcase
      end
      if (n == 600) fork
        begin
          hold_off = 1'b1;
          repeat (800) @(posedge clk_i);
          hold_off = 1'b0;
        end
      join_none
      if ($urandom_range(3) == 0)
        send_pair($urandom_range(1) ? 8'd255 : 8'd0, 8'($urandom), 1'b0, 16'sd0);
      else
        send_pair(8'($urandom), 8'($urandom), 1'b0, 16'sd0);
    end
    in_valid_i <= 1'b0;
    while (audio_q.size() != 0 || hold_off) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
